FILE: hw/rtl/assert_macros.svh
// assertion helpers for the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// same-cycle implication
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: same-cycle implication");

// next-cycle implication
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: next-cycle implication");

`else

`define ASSERT_IMPLIES(label, clk, rst, ante, cons)
`define ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

FILE: hw/rtl/vdma_pkg.sv
package vdma_pkg;

   // item kinds
   localparam logic OP_START = 1'b0;
   localparam logic OP_STEP  = 1'b1;

   // result actions
   localparam logic [2:0] ACT_NONE  = 3'd0;
   localparam logic [2:0] ACT_DATA  = 3'd1;
   localparam logic [2:0] ACT_VRAM  = 3'd2;
   localparam logic [2:0] ACT_VSRAM = 3'd3;
   localparam logic [2:0] ACT_CRAM  = 3'd4;

   // transfer modes (0 and 1 both load)
   localparam logic [1:0] MODE_FILL = 2'd2;
   localparam logic [1:0] MODE_COPY = 2'd3;

   // fill target codes
   localparam logic [3:0] TGT_VRAM  = 4'd1;
   localparam logic [3:0] TGT_CRAM  = 4'd3;
   localparam logic [3:0] TGT_VSRAM = 4'd5;

   // register indexes
   localparam int          CSR_IDX_W   = 3;
   localparam int          CSR_DATA_W  = 22;
   localparam logic [2:0]  REG_MODE    = 3'd0;
   localparam logic [2:0]  REG_SOURCE  = 3'd1;
   localparam logic [2:0]  REG_LENGTH  = 3'd2;
   localparam logic [2:0]  REG_FILL    = 3'd3;
   localparam logic [2:0]  REG_TARGET  = 3'd4;
   localparam logic [2:0]  REG_DEST    = 3'd5;
   localparam logic [2:0]  REG_STEP    = 3'd6;

   typedef struct packed {
      logic [1:0]  dma_mode;
      logic [21:0] source_start;
      logic [15:0] length_start;
      logic [7:0]  fill_byte;
      logic [3:0]  target_code;
      logic [16:0] dest_start;
      logic [7:0]  dest_step;
   } cfg_type;

   typedef struct packed {
      logic        opcode;
      logic        hold;
      logic [15:0] read_data;
   } req_item_type;

   typedef struct packed {
      logic [2:0]  action;
      logic [16:0] write_address;
      logic [15:0] write_data;
      logic [23:0] read_address;
      logic [15:0] remaining;
      logic        pending_out;
      logic        load_active;
      logic        finished;
   } rsp_item_type;

endpackage

FILE: hw/rtl/vdma_csr.sv
module vdma_csr (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_we,
   input  logic [vdma_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [vdma_pkg::CSR_DATA_W-1:0]    csr_wdata,
   output vdma_pkg::cfg_type                  cfg
);
   import vdma_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            REG_MODE:   cfg_in.dma_mode     = csr_wdata[1:0];
            REG_SOURCE: cfg_in.source_start = csr_wdata[21:0];
            REG_LENGTH: cfg_in.length_start = csr_wdata[15:0];
            REG_FILL:   cfg_in.fill_byte    = csr_wdata[7:0];
            REG_TARGET: cfg_in.target_code  = csr_wdata[3:0];
            REG_DEST:   cfg_in.dest_start   = csr_wdata[16:0];
            REG_STEP:   cfg_in.dest_step    = csr_wdata[7:0];
            default:    cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

FILE: hw/rtl/vdma_core.sv
`include "assert_macros.svh"

module vdma_core (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    en,
   input  vdma_pkg::req_item_type  item,
   input  vdma_pkg::cfg_type       cfg,
   output vdma_pkg::rsp_item_type  result
);
   import vdma_pkg::*;

   logic [21:0] src_ff, src_in;
   logic [15:0] len_ff, len_in;
   logic [16:0] dst_ff, dst_in;
   logic        pend_ff, pend_in;
   logic        act_ff, act_in;
   logic        done;

   always_comb begin
      src_in  = src_ff;
      len_in  = len_ff;
      dst_in  = dst_ff;
      pend_in = pend_ff;
      act_in  = act_ff;
      done    = 1'b0;
      result  = '0;
      if (item.opcode == OP_START) begin
         src_in  = cfg.source_start;
         len_in  = cfg.length_start;
         dst_in  = cfg.dest_start;
         pend_in = 1'b1;
         act_in  = 1'b0;
      end else if (pend_ff && !item.hold) begin
         // source wraps inside its low 16 bits
         src_in  = {src_ff[21:16], src_ff[15:0] + 16'd1};
         len_in  = len_ff - 16'd1;
         done    = (len_in == 16'd0);
         pend_in = !done;
         if (!cfg.dma_mode[1]) begin
            act_in            = !done;
            result.action     = ACT_DATA;
            result.write_data = item.read_data;
         end else begin
            dst_in = dst_ff + {9'd0, cfg.dest_step};
            if (cfg.dma_mode == MODE_FILL) begin
               case (cfg.target_code)
                  TGT_VRAM:  result.action = ACT_VRAM;
                  TGT_VSRAM: result.action = ACT_VSRAM;
                  TGT_CRAM:  result.action = ACT_CRAM;
                  default:   result.action = ACT_NONE;
               endcase
               if (result.action != ACT_NONE) begin
                  result.write_address = dst_ff;
                  result.write_data    = {8'd0, cfg.fill_byte};
               end
            end else begin
               result.action        = ACT_VRAM;
               result.write_address = dst_ff;
               result.write_data    = {8'd0, item.read_data[7:0]};
            end
         end
      end

      if (!cfg.dma_mode[1]) begin
         result.read_address = {cfg.dma_mode[0], src_in, 1'b0};
      end else if (cfg.dma_mode == MODE_COPY) begin
         result.read_address = {2'd0, src_in};
      end else begin
         result.read_address = '0;
      end
      result.remaining   = len_in;
      result.pending_out = pend_in;
      result.load_active = act_in;
      result.finished    = done;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         src_ff  <= '0;
         len_ff  <= '0;
         dst_ff  <= '0;
         pend_ff <= 1'b0;
         act_ff  <= 1'b0;
      end else if (en) begin
         src_ff  <= src_in;
         len_ff  <= len_in;
         dst_ff  <= dst_in;
         pend_ff <= pend_in;
         act_ff  <= act_in;
      end
   end

   `ASSERT_IMPLIES(a_finish_clears, clock, reset, result.finished,
                   !result.pending_out && result.remaining == 16'd0)
   `ASSERT_NEXT(a_finish_idles, clock, reset, en && result.finished, !pend_ff)
   `ASSERT_NEXT(a_start_arms, clock, reset, en && item.opcode == OP_START,
                pend_ff && !act_ff)
   `ASSERT_NEXT(a_idle_step_holds, clock, reset,
                en && item.opcode == OP_STEP && !pend_ff,
                len_ff == $past(len_ff) && dst_ff == $past(dst_ff))

endmodule

FILE: hw/rtl/video_dma_load_fill_copy.sv
// an accepted item passes through the input register and then the result register
// throughput: one item per cycle while results drain, limited by the single step update of the transfer counters
// a stalled result keeps one further item parked in the input register
// reset: synchronous, active high; clears configuration registers, counters, pending and load flags,
// and both valid stages
module video_dma_load_fill_copy (
   input  logic                             clock,
   input  logic                             reset,
   // configuration write port
   input  logic                             csr_we,
   input  logic [vdma_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [vdma_pkg::CSR_DATA_W-1:0]  csr_wdata,
   // request stream
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [23:0]                      req_tdata,  // hold, read_data, zero pad
   input  logic                             req_tuser,  // opcode
   // result stream
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   // write_address, write_data, read_address, remaining, pending_out, load_active, zero pad
   output logic [79:0]                      rsp_tdata,
   output logic [2:0]                       rsp_tuser,  // action
   output logic                             rsp_tlast   // finished
);
   import vdma_pkg::*;

   cfg_type      cfg;
   rsp_item_type core_result;

   // input register stage
   logic         in_valid_ff, in_valid_in;
   req_item_type in_item_ff;

   // result register stage
   logic         out_valid_ff, out_valid_in;
   rsp_item_type out_item_ff;

   logic         advance;   // result register can take the next item
   logic         take_req;

   assign advance  = !out_valid_ff || rsp_tready;
   assign take_req = req_tvalid && req_tready;

   // input stage frees up whenever its item moves on
   assign req_tready = !in_valid_ff || advance;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (take_req) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
      out_valid_in = out_valid_ff;
      if (advance) begin
         out_valid_in = in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (take_req) begin
         in_item_ff.opcode    <= req_tuser;
         in_item_ff.hold      <= req_tdata[0];
         in_item_ff.read_data <= req_tdata[16:1];
      end
      if (advance && in_valid_ff) begin
         out_item_ff <= core_result;
      end
   end

   vdma_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   // transfer state moves only when the item is handed to the result register
   vdma_core u_core (
      .clock  (clock),
      .reset  (reset),
      .en     (advance && in_valid_ff),
      .item   (in_item_ff),
      .cfg    (cfg),
      .result (core_result)
   );

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tuser  = out_item_ff.action;
   assign rsp_tlast  = out_item_ff.finished;
   assign rsp_tdata  = {5'd0,
                        out_item_ff.load_active,
                        out_item_ff.pending_out,
                        out_item_ff.remaining,
                        out_item_ff.read_address,
                        out_item_ff.write_data,
                        out_item_ff.write_address};

endmodule
